// ----- hw/rtl/i2crm_pkg.sv -----
// Shared constants and codes of the I2C register master.
package i2crm_pkg;

    // Operation codes carried by each phase tick
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_POLL_LIMIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_WAIT_PHASES = 2'd1;

    // Reset values of the configuration registers
    localparam logic [7:0] ACK_POLL_LIMIT_RST   = 8'd250;
    localparam logic [7:0] READ_WAIT_PHASES_RST = 8'd16;

    // Bits per byte on the bus
    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

endpackage

// ----- hw/rtl/i2c_register_master_unit.sv -----
// I2C register master: phase sequencer with input and result registers.
//
// Each input transaction is one bus phase tick. Operation write or read starts
// a register transaction when the sequencer is idle; otherwise it is a plain
// tick. Each tick gives exactly one result transaction with the line levels to
// drive (scl, sda_out, sda_drive), busy, a done pulse with the ack error flag,
// and the byte of the last completed read.
// Channels use valid/stall; a tick is taken when i_in_valid is high and
// o_in_stall low, a result when o_out_valid is high and i_out_stall low.
// A tick lands in the input register, the sequencer step runs on it and the
// result is loaded into the output register once that slot is free or taken.
// One tick per cycle is taken while the receiver does not stall.
// When the receiver stalls, the output register holds; the input register
// holds one more tick, after which o_in_stall rises.
// Users write configuration (i_cfg_valid/o_cfg_ready) only while idle; unchecked.
// Reset (synchronous, active low) empties both registers, returns the
// sequencer to idle and loads the default poll limit and read wait.
module i2c_register_master_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration write channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [i2crm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    // tick input channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_operation,
    input  logic [7:0] i_device_address,
    input  logic [7:0] i_register_address,
    input  logic [7:0] i_write_data,
    input  logic       i_sda_in,
    // result output channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_scl,
    output logic       o_sda_out,
    output logic       o_sda_drive,
    output logic       o_busy_res,
    output logic       o_done_res,
    output logic       o_ack_error,
    output logic [7:0] o_read_data
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_START, ST_DEV, ST_ACK_DEV, ST_REG, ST_ACK_REG, ST_DATA,
        ST_ACK_DATA, ST_RSTART, ST_RDEV, ST_ACK_RDEV, ST_WAIT, ST_READ,
        ST_NACK, ST_STOP, ST_STOP_ERR
    } t_step;

    // configuration
    logic [7:0] r_ack_poll_limit;
    logic [7:0] r_read_wait;

    // input register
    logic       r_in_valid;
    logic [1:0] r_in_op;
    logic [7:0] r_in_dev;
    logic [7:0] r_in_reg;
    logic [7:0] r_in_data;
    logic       r_in_sda;

    // sequencer state
    t_step      r_step,   n_step;
    logic [1:0] r_phase,  n_phase;
    logic [3:0] r_bits,   n_bits;
    logic [7:0] r_shift,  n_shift;
    logic [7:0] r_dev,    n_dev;
    logic [7:0] r_reg,    n_reg;
    logic [7:0] r_data,   n_data;
    logic       r_is_read, n_is_read;
    logic [7:0] r_poll,   n_poll;
    logic [7:0] r_wait,   n_wait;
    logic [7:0] r_last,   n_last;

    // result register
    logic       r_out_valid;
    logic       r_scl, n_scl;
    logic       r_so, n_so;
    logic       r_dr, n_dr;
    logic       r_busy, n_busy;
    logic       r_done, n_done;
    logic       r_err, n_err;

    logic       advance;
    logic       fire;
    logic       in_take;

    // handshake: result slot frees when empty or taken
    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // one sequencer phase
    always_comb begin
        n_step    = r_step;
        n_phase   = r_phase;
        n_bits    = r_bits;
        n_shift   = r_shift;
        n_dev     = r_dev;
        n_reg     = r_reg;
        n_data    = r_data;
        n_is_read = r_is_read;
        n_poll    = r_poll;
        n_wait    = r_wait;
        n_last    = r_last;
        n_scl     = 1'b1;
        n_so      = 1'b1;
        n_dr      = 1'b0;
        n_done    = 1'b0;
        n_err     = 1'b0;

        // start of a transaction, only from idle
        if (r_step == ST_IDLE &&
            (r_in_op == i2crm_pkg::OP_WRITE || r_in_op == i2crm_pkg::OP_READ)) begin
            n_dev     = r_in_dev;
            n_reg     = r_in_reg;
            n_data    = r_in_data;
            n_is_read = (r_in_op == i2crm_pkg::OP_READ);
            n_step    = ST_START;
            n_phase   = 2'd0;
            n_bits    = 4'd0;
            n_poll    = 8'd0;
        end
        n_busy = (n_step != ST_IDLE);

        case (n_step)
            ST_START, ST_RSTART: begin
                n_dr = 1'b1;
                case (n_phase)
                    2'd0: begin
                        n_scl = (n_step == ST_START);
                        n_so  = 1'b1;
                    end
                    2'd1: begin
                        n_scl = 1'b1;
                        n_so  = 1'b1;
                    end
                    2'd2: begin
                        n_scl = 1'b1;
                        n_so  = 1'b0;
                    end
                    default: begin
                        n_scl = 1'b0;
                        n_so  = 1'b0;
                    end
                endcase
                if (n_phase == 2'd3) begin
                    n_shift = (n_step == ST_START) ? n_dev : n_dev + 8'd1;
                    n_step  = (n_step == ST_START) ? ST_DEV : ST_RDEV;
                    n_bits  = 4'd0;
                    n_phase = 2'd0;
                end else begin
                    n_phase = n_phase + 2'd1;
                end
            end
            ST_DEV, ST_REG, ST_DATA, ST_RDEV: begin
                n_dr  = 1'b1;
                n_so  = n_shift[7];
                n_scl = (n_phase == 2'd1);
                if (n_phase >= 2'd2) begin
                    n_shift = {n_shift[6:0], 1'b0};
                    n_bits  = n_bits + 4'd1;
                    n_phase = 2'd0;
                    if (n_bits >= i2crm_pkg::BITS_PER_BYTE) begin
                        n_poll = 8'd0;
                        case (n_step)
                            ST_DEV:  n_step = ST_ACK_DEV;
                            ST_REG:  n_step = ST_ACK_REG;
                            ST_DATA: n_step = ST_ACK_DATA;
                            default: n_step = ST_ACK_RDEV;
                        endcase
                    end
                end else begin
                    n_phase = n_phase + 2'd1;
                end
            end
            ST_ACK_DEV, ST_ACK_REG, ST_ACK_DATA, ST_ACK_RDEV: begin
                if (n_phase == 2'd0) begin
                    n_scl   = 1'b0;
                    n_phase = 2'd1;
                end else if (n_phase == 2'd1) begin
                    // poll the acknowledge while clock is high
                    n_scl = 1'b1;
                    if (!r_in_sda) begin
                        n_phase = 2'd2;
                    end else begin
                        if (n_poll != 8'hFF) begin
                            n_poll = n_poll + 8'd1;
                        end
                        if (n_poll >= r_ack_poll_limit) begin
                            n_step  = ST_STOP_ERR;
                            n_phase = 2'd0;
                        end
                    end
                end else begin
                    n_scl = 1'b0;
                    case (n_step)
                        ST_ACK_DEV: begin
                            n_step  = ST_REG;
                            n_shift = n_reg;
                            n_bits  = 4'd0;
                            n_phase = 2'd0;
                        end
                        ST_ACK_REG: begin
                            if (n_is_read) begin
                                n_step  = ST_RSTART;
                                n_phase = 2'd0;
                            end else begin
                                n_step  = ST_DATA;
                                n_shift = n_data;
                                n_bits  = 4'd0;
                                n_phase = 2'd0;
                            end
                        end
                        ST_ACK_DATA: begin
                            n_step  = ST_STOP;
                            n_phase = 2'd0;
                        end
                        default: begin
                            // read address acknowledged
                            if (r_read_wait == 8'd0) begin
                                n_step  = ST_READ;
                                n_shift = 8'd0;
                                n_bits  = 4'd0;
                                n_phase = 2'd0;
                            end else begin
                                n_wait  = r_read_wait;
                                n_step  = ST_WAIT;
                                n_phase = 2'd0;
                            end
                        end
                    endcase
                end
            end
            ST_WAIT: begin
                n_scl  = 1'b0;
                n_wait = n_wait - 8'd1;
                if (n_wait == 8'd0) begin
                    n_step  = ST_READ;
                    n_shift = 8'd0;
                    n_bits  = 4'd0;
                    n_phase = 2'd0;
                end
            end
            ST_READ: begin
                n_scl = (n_phase == 2'd1);
                if (n_phase == 2'd1) begin
                    n_shift = {n_shift[6:0], r_in_sda};
                end
                if (n_phase >= 2'd2) begin
                    n_bits  = n_bits + 4'd1;
                    n_phase = 2'd0;
                    if (n_bits >= i2crm_pkg::BITS_PER_BYTE) begin
                        n_last = n_shift;
                        n_step = ST_NACK;
                    end
                end else begin
                    n_phase = n_phase + 2'd1;
                end
            end
            ST_NACK: begin
                n_dr  = 1'b1;
                n_scl = (n_phase == 2'd1);
                if (n_phase >= 2'd2) begin
                    n_step  = ST_STOP;
                    n_phase = 2'd0;
                end else begin
                    n_phase = n_phase + 2'd1;
                end
            end
            ST_STOP, ST_STOP_ERR: begin
                n_dr = 1'b1;
                if (n_phase == 2'd0) begin
                    n_scl   = 1'b0;
                    n_so    = 1'b0;
                    n_phase = 2'd1;
                end else if (n_phase == 2'd1) begin
                    n_scl   = 1'b1;
                    n_so    = 1'b0;
                    n_phase = 2'd2;
                end else begin
                    n_done  = 1'b1;
                    n_err   = (n_step == ST_STOP_ERR);
                    n_step  = ST_IDLE;
                    n_phase = 2'd0;
                end
            end
            default: begin
                n_scl = 1'b1;
                n_so  = 1'b1;
                n_dr  = 1'b0;
            end
        endcase
    end

    // state, input register, result register and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_poll_limit <= i2crm_pkg::ACK_POLL_LIMIT_RST;
            r_read_wait      <= i2crm_pkg::READ_WAIT_PHASES_RST;
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_step           <= ST_IDLE;
            r_phase          <= 2'd0;
            r_bits           <= 4'd0;
            r_shift          <= 8'd0;
            r_dev            <= 8'd0;
            r_reg            <= 8'd0;
            r_data           <= 8'd0;
            r_is_read        <= 1'b0;
            r_poll           <= 8'd0;
            r_wait           <= 8'd0;
            r_last           <= 8'd0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    i2crm_pkg::CFG_ACK_POLL_LIMIT:   r_ack_poll_limit <= i_cfg_data;
                    i2crm_pkg::CFG_READ_WAIT_PHASES: r_read_wait      <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_take) begin
                r_in_op   <= i_operation;
                r_in_dev  <= i_device_address;
                r_in_reg  <= i_register_address;
                r_in_data <= i_write_data;
                r_in_sda  <= i_sda_in;
            end
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= fire;
            end
            if (fire) begin
                r_step    <= n_step;
                r_phase   <= n_phase;
                r_bits    <= n_bits;
                r_shift   <= n_shift;
                r_dev     <= n_dev;
                r_reg     <= n_reg;
                r_data    <= n_data;
                r_is_read <= n_is_read;
                r_poll    <= n_poll;
                r_wait    <= n_wait;
                r_last    <= n_last;
                r_scl     <= n_scl;
                r_so      <= n_so;
                r_dr      <= n_dr;
                r_busy    <= n_busy;
                r_done    <= n_done;
                r_err     <= n_err;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_scl       = r_scl;
    assign o_sda_out   = r_so;
    assign o_sda_drive = r_dr;
    assign o_busy_res  = r_busy;
    assign o_done_res  = r_done;
    assign o_ack_error = r_err;
    assign o_read_data = r_last;

    // a done pulse always falls inside a busy transaction
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_done |-> r_busy)
        else $error("done result without busy");

    // the error flag only appears with done
    a_err_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_err |-> r_done)
        else $error("ack error without done");

    // the sequencer only advances on a processed tick
    a_step_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fire |=> $stable(r_step) && $stable(r_phase))
        else $error("sequencer moved without a tick");

    // a result that finishes a transaction leaves the sequencer idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && n_done |=> r_step == ST_IDLE)
        else $error("sequencer not idle after stop");

endmodule
